/* hdl/vpdc_pkg.sv */
// Shared types, widths and constants for the vibratory pump duty controller.
// No dependencies; imported by every other file of the block.
package vpdc_pkg;

  localparam int IN_W    = 12;
  localparam int SLOPE_W = 16;
  localparam int DUTY_W  = 13;
  localparam int CPS_W   = 8;

  localparam int POLY_W  = 58;
  localparam int NUM_W   = 64;
  localparam int DEN_W   = 58;
  localparam int QUO_W   = 12;
  localparam int CMP_W   = 70;

  localparam int FRONT_STAGES = 5;
  localparam int BACK_STAGES  = 2;
  localparam int LATENCY      = FRONT_STAGES + QUO_W + BACK_STAGES;

  localparam logic [CPS_W-1:0]  CPS_RESET = 8'd50;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 13'd4096;

  localparam logic signed [POLY_W-1:0] FPC_C0 = 58'sd966367641600000;
  localparam logic signed [POLY_W-1:0] FPC_C1 = 58'sd24000;
  localparam logic signed [POLY_W-1:0] FPC_C2 = 58'sd1500;
  localparam logic signed [POLY_W-1:0] FPC_C3 = 58'sd685;
  localparam logic signed [POLY_W-1:0] FPC_C4 = 58'sd45;

  localparam logic [17:0] RECIP_M   = 18'd209716;
  localparam int          RAMP_BASE = 1024;
  localparam int          TRIM_BASE = 8192;
  localparam int          RAMP_EDGE = 512;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_RAMP    = 2'd1,
    MODE_TRIM    = 2'd2,
    MODE_TRICKLE = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [IN_W-1:0]  dmag;
    logic             lim_zero;
  } front_t;

  typedef struct packed {
    mode_t            mode;
    logic [IN_W-1:0]  dmag;
    logic             cap_full;
    logic             cap_sat;
    logic             ff_zero;
    logic             ff_full;
    logic             ff_sat;
  } side_t;

  function automatic logic signed [POLY_W-1:0] to_s(input logic [47:0] x);
    return $signed({10'b0, x});
  endfunction

endpackage

/* hdl/vpdc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on vpdc_pkg for widths.
module vpdc_div import vpdc_pkg::*; (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W-1];
  logic [QUO_W-1:0] quo_r [QUO_W];

  logic [NUM_W-1:0] rem_in [QUO_W];
  logic [DEN_W-1:0] den_in [QUO_W];
  logic [QUO_W-1:0] quo_in [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int B = QUO_W - 1 - s;
    logic [CMP_W-1:0] dsh;
    logic [CMP_W-1:0] rext;
    logic [CMP_W-1:0] diff;
    logic             take;

    if (s == 0) begin : g_first
      assign rem_in[s] = num;
      assign den_in[s] = den;
      assign quo_in[s] = '0;
    end else begin : g_next
      assign rem_in[s] = rem_r[s-1];
      assign den_in[s] = den_r[s-1];
      assign quo_in[s] = quo_r[s-1];
    end

    assign dsh  = CMP_W'(den_in[s]) << B;
    assign rext = CMP_W'(rem_in[s]);
    assign take = (rext >= dsh);
    assign diff = rext - dsh;

    always_ff @(posedge clk) begin
      rem_r[s] <= take ? diff[NUM_W-1:0] : rem_in[s];
      quo_r[s] <= {quo_in[s][QUO_W-2:0], take};
    end

    if (s < QUO_W - 1) begin : g_den
      always_ff @(posedge clk) begin
        den_r[s] <= den_in[s];
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

/* hdl/vibratory_pump_duty_controller.sv */
// Top level: pressure-profiled pump duty from a click-volume polynomial.
// Depends on vpdc_pkg and vpdc_div.
//
//   channel  | handshake              | beat
//   ---------+------------------------+--------------------------------------
//   input    | start, busy            | target, limit, pressure, flow, slope
//   result   | out_valid (strobe)     | pump_duty
//   config   | cfg_we                 | max_clicks_per_second
//
// One beat enters every cycle; busy is always low.
// A result passes through 5 polynomial/setup stages,
// 12 divider stages (one quotient bit each) and 2 combine stages.
// Synchronous reset clears valid bits and sets the click rate to 50.
// Results are strobed for one cycle; the receiver cannot stall.
module vibratory_pump_duty_controller import vpdc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [IN_W-1:0]           in_target_pressure,
  input  logic [IN_W-1:0]           in_flow_limit,
  input  logic [IN_W-1:0]           in_measured_pressure,
  input  logic [IN_W-1:0]           in_measured_flow,
  input  logic signed [SLOPE_W-1:0] in_pressure_slope,
  input  logic                      cfg_we,
  input  logic [CPS_W-1:0]          cfg_wdata,
  output logic                      out_valid,
  output logic [DUTY_W-1:0]         out_pump_duty
);

  logic [CPS_W-1:0] cps_r;
  logic [FRONT_STAGES-1:0] fv_r;
  logic [QUO_W-1:0] dv_r;
  logic av_r;
  logic out_valid_r;
  logic [DUTY_W-1:0] out_duty_r, out_duty_nxt;

  front_t f1_r, f2_r, f3_r, f4_r, f5_r, f1_nxt;
  logic [IN_W-1:0] p1_r, p2p_r, flim1_r, flim2_r, flim3_r, flim4_r, flim5_r;
  logic [IN_W-1:0] fm1_r, fm2_r, fm3_r, fm4_r, fm5_r;
  logic [23:0] sq1_r, sq2_r;
  logic [35:0] cu2_r, cu3_r;
  logic [47:0] qd3_r;
  logic signed [POLY_W-1:0] a3_r, fv4_r;
  logic [DEN_W-1:0] d5_r;
  logic full5_r;
  logic [NUM_W-1:0] ncap5_r, nff5_r;

  side_t side_r [QUO_W];
  side_t side_nxt;
  logic [QUO_W-1:0] qcap, qff;

  mode_t mode_a_r;
  logic [DUTY_W-1:0] cap_a_r;
  logic [33:0] pr_a_r;
  logic [35:0] pt_a_r;
  logic [30:0] pf_a_r;

  logic signed [IN_W:0] diff;
  logic [DEN_W-1:0] thr;
  logic [DEN_W-1:0] d_nxt;
  logic fle;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cps_r <= CPS_RESET;
    end else if (cfg_we) begin
      cps_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r        <= '0;
      dv_r        <= '0;
      av_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fv_r        <= {fv_r[FRONT_STAGES-2:0], start & ~busy};
      dv_r        <= {dv_r[QUO_W-2:0], fv_r[FRONT_STAGES-1]};
      av_r        <= dv_r[QUO_W-1];
      out_valid_r <= av_r;
    end
  end

  assign diff = $signed({1'b0, in_target_pressure}) - $signed({1'b0, in_measured_pressure});

  always_comb begin
    f1_nxt.dmag     = diff[IN_W-1:0];
    f1_nxt.lim_zero = (in_flow_limit == '0);
    if (in_target_pressure == '0) begin
      f1_nxt.mode = MODE_OFF;
    end else if (diff > (IN_W+1)'(RAMP_EDGE)) begin
      f1_nxt.mode = MODE_RAMP;
    end else if (diff > 0) begin
      f1_nxt.mode = MODE_TRIM;
    end else if (in_pressure_slope[SLOPE_W-1]) begin
      f1_nxt.mode = MODE_TRICKLE;
    end else begin
      f1_nxt.mode = MODE_OFF;
    end
  end

  // front stages: powers of pressure, polynomial, divisor and numerators
  always_ff @(posedge clk) begin
    f1_r    <= f1_nxt;
    p1_r    <= in_measured_pressure;
    sq1_r   <= 24'(in_measured_pressure) * 24'(in_measured_pressure);
    flim1_r <= in_flow_limit;
    fm1_r   <= in_measured_flow;

    f2_r    <= f1_r;
    p2p_r   <= p1_r;
    sq2_r   <= sq1_r;
    cu2_r   <= 36'(sq1_r) * 36'(p1_r);
    flim2_r <= flim1_r;
    fm2_r   <= fm1_r;

    f3_r    <= f2_r;
    cu3_r   <= cu2_r;
    qd3_r   <= 48'(cu2_r) * 48'(p2p_r);
    a3_r    <= FPC_C0 - ((FPC_C1 * to_s(48'(p2p_r))) <<< 24)
                      - ((FPC_C2 * to_s(48'(sq2_r))) <<< 16);
    flim3_r <= flim2_r;
    fm3_r   <= fm2_r;

    f4_r    <= f3_r;
    fv4_r   <= a3_r + ((FPC_C3 * to_s(48'(cu3_r))) <<< 8) - FPC_C4 * to_s(qd3_r);
    flim4_r <= flim3_r;
    fm4_r   <= fm3_r;

    f5_r    <= f4_r;
    d5_r    <= d_nxt;
    full5_r <= fle || (d_nxt <= thr);
    ncap5_r <= (NUM_W'(flim4_r) * NUM_W'(50000)) << 36;
    nff5_r  <= (NUM_W'(fm4_r) * NUM_W'(50000)) << 36;
    flim5_r <= flim4_r;
    fm5_r   <= fm4_r;
  end

  assign fle   = (fv4_r <= 0);
  assign d_nxt = DEN_W'(fv4_r) + DEN_W'(fv4_r <<< 1);
  assign thr   = (DEN_W'(cps_r) * DEN_W'(50)) << 32;

  vpdc_div u_div_cap (.clk(clk), .num(ncap5_r), .den(d5_r), .quo(qcap));
  vpdc_div u_div_ff  (.clk(clk), .num(nff5_r),  .den(d5_r), .quo(qff));

  always_comb begin
    side_nxt.mode     = f5_r.mode;
    side_nxt.dmag     = f5_r.dmag;
    side_nxt.cap_full = f5_r.lim_zero || full5_r;
    side_nxt.cap_sat  = (DEN_W'({NUM_W'(flim5_r) * NUM_W'(50000), 24'b0}) >= d5_r);
    side_nxt.ff_zero  = (fm5_r == '0);
    side_nxt.ff_full  = full5_r;
    side_nxt.ff_sat   = (DEN_W'({NUM_W'(fm5_r) * NUM_W'(50000), 24'b0}) >= d5_r);
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_nxt;
    for (int i = 1; i < QUO_W; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  logic [DUTY_W-1:0] cap_a, ff_a;
  logic [17:0] trim_num;

  always_comb begin
    cap_a = (side_r[QUO_W-1].cap_full || side_r[QUO_W-1].cap_sat) ? DUTY_FULL
                                                                  : {1'b0, qcap};
    if (side_r[QUO_W-1].ff_zero) begin
      ff_a = '0;
    end else if (side_r[QUO_W-1].ff_full || side_r[QUO_W-1].ff_sat) begin
      ff_a = DUTY_FULL;
    end else begin
      ff_a = {1'b0, qff};
    end
    trim_num = 18'(ff_a) * 18'd19 + 18'(TRIM_BASE) + {side_r[QUO_W-1].dmag, 6'b0};
  end

  always_ff @(posedge clk) begin
    mode_a_r <= side_r[QUO_W-1].mode;
    cap_a_r  <= cap_a;
    pr_a_r   <= 34'({side_r[QUO_W-1].dmag, 4'b0}) * 34'(RECIP_M);
    pt_a_r   <= 36'(trim_num) * 36'(RECIP_M);
    pf_a_r   <= 31'(ff_a) * 31'(RECIP_M);
  end

  logic [14:0] val_b;

  always_comb begin
    case (mode_a_r)
      MODE_RAMP:    val_b = 15'(RAMP_BASE) + 15'(pr_a_r[33:20]);
      MODE_TRIM:    val_b = 15'(pt_a_r[35:22]);
      MODE_TRICKLE: val_b = 15'(pf_a_r[30:20]);
      default:      val_b = '0;
    endcase
    out_duty_nxt = (val_b < 15'(cap_a_r)) ? val_b[DUTY_W-1:0] : cap_a_r;
  end

  always_ff @(posedge clk) begin
    out_duty_r <= out_duty_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pump_duty = out_duty_r;

endmodule

/* hdl/vpdc_checker.sv */
// Port-level checks for the pump duty controller, bound to the top level.
// Depends on vpdc_pkg and vibratory_pump_duty_controller.
module vpdc_checker import vpdc_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [IN_W-1:0]           in_target_pressure,
  input logic                      out_valid,
  input logic [DUTY_W-1:0]         out_pump_duty
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy) else $error("busy raised");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pump_duty <= DUTY_FULL) else $error("duty above full");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid) else $error("beat lost");

  a_zero_target: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_target_pressure == '0) |-> ##LATENCY out_pump_duty == '0)
    else $error("zero target gave nonzero duty");

endmodule

bind vibratory_pump_duty_controller vpdc_checker u_vpdc_checker (.*);
